/* hw/rtl/bslpr_pkg.sv */
// ----------------------------------------------------------------------------
// bslpr_pkg
// Shared types, constants and helper functions of the LED pattern renderer.
// ----------------------------------------------------------------------------
`default_nettype none

package bslpr_pkg;

	localparam int unsigned TICKS_PER_QUARTER_DEF = 24;
	localparam int unsigned NUM_PIX               = 10;
	localparam int unsigned PIX_W                 = 24;
	localparam int unsigned OUT_W                 = NUM_PIX * PIX_W;

	typedef enum logic [3:0] {
		MODE_OFF     = 4'd0,
		MODE_PULSE   = 4'd1,
		MODE_CHASE   = 4'd2,
		MODE_COMET   = 4'd3,
		MODE_SWEEP   = 4'd4,
		MODE_RAINBOW = 4'd5,
		MODE_SPARKLE = 4'd6,
		MODE_HEART   = 4'd7,
		MODE_SCANNER = 4'd8
	} mode_t;

	typedef enum logic {
		REG_MODE   = 1'b0,
		REG_BRIGHT = 1'b1
	} reg_idx_t;

	localparam logic [31:0] HASH_MUL        = 32'd2654435761;
	localparam logic [31:0] HASH_STEP       = 32'd40503;
	localparam logic [7:0]  HB_ATTACK_END   = 8'd46;
	localparam logic [7:0]  HB_SECOND_START = 8'd64;
	localparam logic [7:0]  HB_SECOND_END   = 8'd102;
	localparam logic [31:0] HB_ATTACK_LEN   = 32'd46;
	localparam logic [31:0] HB_DECAY_LEN    = 32'd38;
	localparam logic [8:0]  HB_SECOND_PEAK  = 9'(256 * 6 / 10);
	localparam logic [8:0]  TRAIL_LEVEL     = 9'd56;
	localparam logic [23:0] BLOOD_COLOUR    = 24'hB40028;
	localparam logic [23:0] SCAN_COLOUR     = 24'hFF0000;

	localparam logic [7:0] RAINBOW_OFS [NUM_PIX] = '{
		8'd0, 8'd25, 8'd51, 8'd76, 8'd102, 8'd127, 8'd153, 8'd178, 8'd204, 8'd229
	};

	typedef struct packed {
		logic [31:0] q;
		logic [31:0] r;
	} divmod_t;

	typedef struct packed {
		logic [7:0] pbar;
		logic [7:0] phb;
		logic [1:0] beat;
	} phase_t;

	typedef struct packed {
		logic [23:0] colour;
		logic [8:0]  level;
	} pix_t;

	// quotient and remainder by a constant through its reciprocal, one correction step
	function automatic divmod_t divmod(input logic [31:0] x, input logic [32:0] rcp,
			input logic [31:0] m);
		logic [64:0] prod;
		divmod_t     res;
		prod  = 65'(x) * 65'(rcp);
		res.q = prod[63:32];
		res.r = x - 32'(res.q * m);
		if (res.r >= m) begin
			res.q = res.q + 32'd1;
			res.r = res.r - m;
		end
		return res;
	endfunction

	function automatic logic [23:0] wheel(input logic [7:0] h);
		logic [7:0]  hh;
		logic [7:0]  t;
		logic [23:0] c;
		hh = h;
		if (h < 8'd85) begin
			t = 8'(10'(hh) * 10'd3);
			c = {8'd255 - t, t, 8'd0};
		end else if (h < 8'd170) begin
			hh = h - 8'd85;
			t  = 8'(10'(hh) * 10'd3);
			c  = {8'd0, 8'd255 - t, t};
		end else begin
			hh = h - 8'd170;
			t  = 8'(10'(hh) * 10'd3);
			c  = {t, 8'd0, 8'd255 - t};
		end
		return c;
	endfunction

	// travel path over the pixels
	function automatic logic [3:0] path_pixel(input logic [3:0] pos);
		logic [3:0] p;
		unique case (pos)
			4'd0: p = 4'd1;
			4'd1: p = 4'd0;
			default: p = pos;
		endcase
		return p;
	endfunction

	// column of a pixel for sweep and scanner
	function automatic logic [1:0] pixel_column(input logic [3:0] pix);
		logic [1:0] c;
		unique case (pix)
			4'd1, 4'd5, 4'd6: c = 2'd0;
			4'd0, 4'd4, 4'd7: c = 2'd1;
			4'd3, 4'd8:       c = 2'd2;
			default:          c = 2'd3;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/beat_synced_led_pattern_renderer.sv */
// ----------------------------------------------------------------------------
// beat_synced_led_pattern_renderer
// Renders ten LED colours per music tick in one of nine patterns.
// ----------------------------------------------------------------------------
//  channel   direction  payload
//  s_axis    in         tdata[63:0] tick
//  m_axis    out        tdata[239:0] pixel_0_color .. pixel_9_color, 24 bits each
//  cfg       in         cfg_index 0 pattern_mode, 1 brightness; cfg_data[7:0]
//
//  one tick accepted per cycle while the output is not stalled, result through ten register stages
//  the tick is reduced sixteen bits a stage over the first four stages
//  each stage holds while it is full and the one after it cannot take its data, so bubbles are taken up
//  reset: pattern_mode off, brightness 255, pipeline empty
// ----------------------------------------------------------------------------
`default_nettype none

module beat_synced_led_pattern_renderer #(
	parameter int unsigned TICKS_PER_QUARTER = bslpr_pkg::TICKS_PER_QUARTER_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_axis_tvalid,
	output logic                               s_axis_tready,
	input  wire logic [63:0]                   s_axis_tdata,   // tick
	output logic                               m_axis_tvalid,
	input  wire logic                          m_axis_tready,
	output logic [bslpr_pkg::OUT_W-1:0]        m_axis_tdata,   // pixel_0_color .. pixel_9_color
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic                          cfg_index,
	input  wire logic [7:0]                    cfg_data
);

	localparam int unsigned SEED_W = $clog2((4 * TICKS_PER_QUARTER) /
		(((TICKS_PER_QUARTER / 4) == 0) ? 1 : (TICKS_PER_QUARTER / 4)));

	logic [3:0] mode_q;
	logic [7:0] bright_q;

	logic                                     ph_valid, ph_ready;
	bslpr_pkg::phase_t                        ph_phase;
	logic [SEED_W-1:0]                        ph_seed;
	logic                                     sh_valid, sh_ready;
	bslpr_pkg::pix_t [bslpr_pkg::NUM_PIX-1:0] sh_pix;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= bslpr_pkg::MODE_OFF;
			bright_q <= 8'd255;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				bslpr_pkg::REG_MODE:   mode_q   <= cfg_data[3:0];
				bslpr_pkg::REG_BRIGHT: bright_q <= cfg_data;
				default:               mode_q   <= mode_q;
			endcase
		end
	end

	bslpr_phase #(
		.TICKS_PER_QUARTER(TICKS_PER_QUARTER)
	) u_phase (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.tick      (s_axis_tdata),
		.out_valid (ph_valid),
		.out_ready (ph_ready),
		.phase     (ph_phase),
		.seed      (ph_seed)
	);

	bslpr_shape #(
		.TICKS_PER_QUARTER(TICKS_PER_QUARTER)
	) u_shape (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (ph_valid),
		.in_ready  (ph_ready),
		.phase     (ph_phase),
		.seed      (ph_seed),
		.mode      (mode_q),
		.bright    (bright_q),
		.out_valid (sh_valid),
		.out_ready (sh_ready),
		.pix       (sh_pix)
	);

	bslpr_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sh_valid),
		.in_ready  (sh_ready),
		.pix       (sh_pix),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata)
	);

endmodule

`default_nettype wire

/* hw/rtl/bslpr_phase.sv */
// ----------------------------------------------------------------------------
// bslpr_phase
// Tick to bar and beat phase, beat index and sparkle seed, six stages.
// ----------------------------------------------------------------------------
`default_nettype none

module bslpr_phase #(
	parameter int unsigned TICKS_PER_QUARTER = bslpr_pkg::TICKS_PER_QUARTER_DEF,
	localparam int unsigned SEED_W = $clog2((4 * TICKS_PER_QUARTER) /
		(((TICKS_PER_QUARTER / 4) == 0) ? 1 : (TICKS_PER_QUARTER / 4)))
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [63:0]          tick,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output bslpr_pkg::phase_t         phase,
	output logic [SEED_W-1:0]         seed
);

	localparam int unsigned BAR = 4 * TICKS_PER_QUARTER;
	localparam int unsigned TPS = ((TICKS_PER_QUARTER / 4) == 0) ? 1 : (TICKS_PER_QUARTER / 4);
	localparam int unsigned SPB = BAR / TPS;
	localparam int unsigned RW  = $clog2(BAR);
	localparam int unsigned BW  = $clog2(TICKS_PER_QUARTER);
	localparam logic [32:0] RCP_BAR = 33'((64'd1 << 32) / 64'(BAR));
	localparam logic [32:0] RCP_TPS = 33'((64'd1 << 32) / 64'(TPS));
	localparam logic [32:0] RCP_SPB = 33'((64'd1 << 32) / 64'(SPB));
	localparam logic [32:0] RCP_TPB = 33'((64'd1 << 32) / 64'(TICKS_PER_QUARTER));

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic rdy_1, rdy_2, rdy_3, rdy_4, rdy_5, rdy_6;

	logic [RW-1:0]     rbar_s1, rbar_s2, rbar_s3, rbar_s4;
	logic [RW-1:0]     rs_s1, rs_s2, rs_s3;
	logic [47:0]       tick_s1;
	logic [31:0]       tick_s2;
	logic [15:0]       tick_s3;
	logic [15:0]       qhi_s3;
	logic [31:0]       q32_s4;
	logic [1:0]        beat_s5, beat_s6;
	logic [BW-1:0]     rbeat_s5;
	logic [7:0]        pbar_s5, pbar_s6;
	logic [SEED_W-1:0] seed_s5, seed_s6;
	logic [7:0]        phb_s6;

	bslpr_pkg::divmod_t dm_b1, dm_t1, dm_b2, dm_t2, dm_b3, dm_t3, dm_b4, dm_t4;
	bslpr_pkg::divmod_t dm_bar5, dm_seed5, dm_beat6;
	logic [1:0]    beat5;
	logic [RW-1:0] rbeat5;

	assign rdy_6    = !v_s6 || out_ready;
	assign rdy_5    = !v_s5 || rdy_6;
	assign rdy_4    = !v_s4 || rdy_5;
	assign rdy_3    = !v_s3 || rdy_4;
	assign rdy_2    = !v_s2 || rdy_3;
	assign rdy_1    = !v_s1 || rdy_2;
	assign in_ready = rdy_1;

	// long division of the tick, sixteen bits a stage
	always_comb begin
		dm_b1 = bslpr_pkg::divmod(32'(tick[63:48]), RCP_BAR, 32'(BAR));
		dm_t1 = bslpr_pkg::divmod(32'(tick[63:48]), RCP_TPS, 32'(TPS));
		dm_b2 = bslpr_pkg::divmod(32'({rbar_s1, tick_s1[47:32]}), RCP_BAR, 32'(BAR));
		dm_t2 = bslpr_pkg::divmod(32'({rs_s1, tick_s1[47:32]}), RCP_TPS, 32'(TPS));
		dm_b3 = bslpr_pkg::divmod(32'({rbar_s2, tick_s2[31:16]}), RCP_BAR, 32'(BAR));
		dm_t3 = bslpr_pkg::divmod(32'({rs_s2, tick_s2[31:16]}), RCP_TPS, 32'(TPS));
		dm_b4 = bslpr_pkg::divmod(32'({rbar_s3, tick_s3}), RCP_BAR, 32'(BAR));
		dm_t4 = bslpr_pkg::divmod(32'({rs_s3, tick_s3}), RCP_TPS, 32'(TPS));
	end

	always_comb begin
		if (rbar_s4 >= RW'(3 * TICKS_PER_QUARTER)) begin
			beat5  = 2'd3;
			rbeat5 = rbar_s4 - RW'(3 * TICKS_PER_QUARTER);
		end else if (rbar_s4 >= RW'(2 * TICKS_PER_QUARTER)) begin
			beat5  = 2'd2;
			rbeat5 = rbar_s4 - RW'(2 * TICKS_PER_QUARTER);
		end else if (rbar_s4 >= RW'(TICKS_PER_QUARTER)) begin
			beat5  = 2'd1;
			rbeat5 = rbar_s4 - RW'(TICKS_PER_QUARTER);
		end else begin
			beat5  = 2'd0;
			rbeat5 = rbar_s4;
		end
		dm_bar5  = bslpr_pkg::divmod(32'({rbar_s4, 8'd0}), RCP_BAR, 32'(BAR));
		dm_seed5 = bslpr_pkg::divmod(q32_s4, RCP_SPB, 32'(SPB));
		dm_beat6 = bslpr_pkg::divmod(32'({rbeat_s5, 8'd0}), RCP_TPB, 32'(TICKS_PER_QUARTER));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (rdy_1) v_s1 <= in_valid;
			if (rdy_2) v_s2 <= v_s1;
			if (rdy_3) v_s3 <= v_s2;
			if (rdy_4) v_s4 <= v_s3;
			if (rdy_5) v_s5 <= v_s4;
			if (rdy_6) v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_1) begin
			rbar_s1 <= dm_b1.r[RW-1:0];
			rs_s1   <= dm_t1.r[RW-1:0];
			tick_s1 <= tick[47:0];
		end
		if (rdy_2) begin
			rbar_s2 <= dm_b2.r[RW-1:0];
			rs_s2   <= dm_t2.r[RW-1:0];
			tick_s2 <= tick_s1[31:0];
		end
		if (rdy_3) begin
			rbar_s3 <= dm_b3.r[RW-1:0];
			rs_s3   <= dm_t3.r[RW-1:0];
			qhi_s3  <= dm_t3.q[15:0];
			tick_s3 <= tick_s2[15:0];
		end
		if (rdy_4) begin
			rbar_s4 <= dm_b4.r[RW-1:0];
			q32_s4  <= {qhi_s3, dm_t4.q[15:0]};
		end
		if (rdy_5) begin
			beat_s5  <= beat5;
			rbeat_s5 <= rbeat5[BW-1:0];
			pbar_s5  <= dm_bar5.q[7:0];
			seed_s5  <= dm_seed5.r[SEED_W-1:0];
		end
		if (rdy_6) begin
			beat_s6 <= beat_s5;
			pbar_s6 <= pbar_s5;
			seed_s6 <= seed_s5;
			phb_s6  <= dm_beat6.q[7:0];
		end
	end

	assign out_valid  = v_s6;
	assign phase.pbar = pbar_s6;
	assign phase.phb  = phb_s6;
	assign phase.beat = beat_s6;
	assign seed       = seed_s6;

endmodule

`default_nettype wire

/* hw/rtl/bslpr_shape.sv */
// ----------------------------------------------------------------------------
// bslpr_shape
// Pattern levels, hues and positions, then colour and level per pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module bslpr_shape #(
	parameter int unsigned TICKS_PER_QUARTER = bslpr_pkg::TICKS_PER_QUARTER_DEF,
	localparam int unsigned SEED_W = $clog2((4 * TICKS_PER_QUARTER) /
		(((TICKS_PER_QUARTER / 4) == 0) ? 1 : (TICKS_PER_QUARTER / 4)))
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   in_valid,
	output logic                                        in_ready,
	input  wire bslpr_pkg::phase_t                      phase,
	input  wire logic [SEED_W-1:0]                      seed,
	input  wire logic [3:0]                             mode,
	input  wire logic [7:0]                             bright,
	output logic                                        out_valid,
	input  wire logic                                   out_ready,
	output bslpr_pkg::pix_t [bslpr_pkg::NUM_PIX-1:0]    pix
);

	localparam logic [32:0] RCP_ATT = 33'((64'd1 << 32) / 64'd46);
	localparam logic [32:0] RCP_DEC = 33'((64'd1 << 32) / 64'd38);
	localparam logic [32:0] RCP_PIX = 33'((64'd1 << 32) / 64'(bslpr_pkg::NUM_PIX));

	typedef enum logic [1:0] {
		HB_NONE,
		HB_FIRST,
		HB_SECOND
	} hb_zone_t;

	logic v_s7, v_s8, v_s9;
	logic rdy_7, rdy_8, rdy_9;
	logic [8:0] lvbr;

	// stage 7
	logic [16:0]  sq_s7;
	logic [7:0]   a1_s7, a2_s7;
	hb_zone_t     zone_s7;
	logic [31:0]  hv_s7 [3];
	logic [3:0]   head_s7;
	logic [7:0]   huebar_s7, huebeat_s7;
	logic [9:0]   d_s7 [4];
	logic [1:0]   eye_s7, behind_s7;
	logic         behind_ok_s7;

	// stage 8
	logic [8:0]   lvp_s8, hb_s8, trail_s8;
	logic [3:0]   sidx_s8 [3];
	logic [7:0]   shue_s8 [3];
	logic [8:0]   swl_s8 [4];
	logic [8:0]   cml_s8 [4];
	logic [3:0]   at_s8 [4];
	logic [7:0]   huebar_s8, huebeat_s8;
	logic [1:0]   eye_s8, behind_s8;
	logic         behind_ok_s8;

	bslpr_pkg::pix_t [bslpr_pkg::NUM_PIX-1:0] pix_s9;

	// stage 7 logic
	logic [8:0]   rem7;
	logic [7:0]   phb_m7;
	hb_zone_t     zone7;
	logic [31:0]  hmul7;
	logic [31:0]  hv7 [3];
	logic [11:0]  head_p7;
	logic [15:0]  hue_p7;
	logic [8:0]   ph2_7;
	logic [9:0]   phs7, pos7, a7;
	logic [9:0]   d7 [4];
	logic [8:0]   ph9_7;
	logic         fwd7;
	logic [9:0]   phr7, eye_t7;
	logic [1:0]   behind7;
	logic         behind_ok7;
	bslpr_pkg::divmod_t dm_a1, dm_a2;

	assign lvbr = {1'b0, bright} + 9'd1;

	assign rdy_9    = !v_s9 || out_ready;
	assign rdy_8    = !v_s8 || rdy_9;
	assign rdy_7    = !v_s7 || rdy_8;
	assign in_ready = rdy_7;

	always_comb begin
		rem7   = 9'd256 - {1'b0, phase.phb};
		phb_m7 = phase.phb - bslpr_pkg::HB_SECOND_START;
		dm_a1  = bslpr_pkg::divmod(32'({phase.phb, 8'd0}), RCP_ATT, bslpr_pkg::HB_ATTACK_LEN);
		dm_a2  = bslpr_pkg::divmod(32'({phb_m7, 8'd0}), RCP_DEC, bslpr_pkg::HB_DECAY_LEN);
		zone7  = HB_NONE;
		if (!phase.beat[0]) begin
			if (phase.phb < bslpr_pkg::HB_ATTACK_END) begin
				zone7 = HB_FIRST;
			end else if (phase.phb >= bslpr_pkg::HB_SECOND_START &&
					phase.phb < bslpr_pkg::HB_SECOND_END) begin
				zone7 = HB_SECOND;
			end
		end
		hmul7 = 32'(32'(seed) * bslpr_pkg::HASH_MUL);
		for (int k = 0; k < 3; k++) begin
			hv7[k] = hmul7 + 32'(32'(k) * bslpr_pkg::HASH_STEP);
		end
		head_p7 = 12'(phase.pbar) * 12'd10;
		hue_p7  = 16'(phase.pbar) * 16'd255;
		// sweep goes out and back once per bar
		ph2_7 = {phase.pbar, 1'b0};
		phs7  = (ph2_7 > 9'd256) ? (10'd512 - 10'(ph2_7)) : 10'(ph2_7);
		pos7  = 10'(phs7 * 10'd3);
		for (int i = 0; i < 4; i++) begin
			a7    = 10'(i * 256);
			d7[i] = (a7 >= pos7) ? (a7 - pos7) : (pos7 - a7);
		end
		// scanner bounces twice per bar
		ph9_7  = {phase.pbar[6:0], 2'b00};
		fwd7   = ph9_7 <= 9'd256;
		phr7   = fwd7 ? 10'(ph9_7) : (10'd512 - 10'(ph9_7));
		eye_t7 = 10'(phr7 * 10'd3) + 10'd128;
		if (fwd7) begin
			behind_ok7 = eye_t7[9:8] != 2'd0;
			behind7    = eye_t7[9:8] - 2'd1;
		end else begin
			behind_ok7 = eye_t7[9:8] != 2'd3;
			behind7    = eye_t7[9:8] + 2'd1;
		end
	end

	// stage 8 logic
	logic [8:0]  hb8, t8;
	logic [16:0] hbp8, trp8;
	logic [17:0] swp8;
	logic [10:0] cmp8;
	logic [3:0]  sidx8 [3];
	logic [8:0]  swl8 [4];
	logic [8:0]  cml8 [4];
	logic [3:0]  at8 [4];
	bslpr_pkg::divmod_t dm_px;

	always_comb begin
		t8   = 9'd256 - 9'(a2_s7);
		hbp8 = 17'(t8) * 17'(bslpr_pkg::HB_SECOND_PEAK);
		unique case (zone_s7)
			HB_FIRST:  hb8 = 9'd256 - 9'(a1_s7);
			HB_SECOND: hb8 = hbp8[16:8];
			default:   hb8 = 9'd0;
		endcase
		for (int k = 0; k < 3; k++) begin
			dm_px    = bslpr_pkg::divmod(32'(hv_s7[k][31:8]), RCP_PIX,
				32'(bslpr_pkg::NUM_PIX));
			sidx8[k] = dm_px.r[3:0];
		end
		for (int i = 0; i < 4; i++) begin
			swp8    = 18'(10'd256 - d_s7[i]) * 18'(lvbr);
			swl8[i] = (d_s7[i] < 10'd256) ? swp8[16:8] : 9'd0;
			cmp8    = 11'(lvbr) * 11'(4 - i);
			cml8[i] = cmp8[10:2];
			at8[i]  = (head_s7 >= 4'(i)) ? (head_s7 - 4'(i)) : (head_s7 + 4'(10 - i));
		end
		trp8 = 17'(lvbr) * 17'(bslpr_pkg::TRAIL_LEVEL);
	end

	// stage 9 logic
	logic [8:0]  sel9, lvb9;
	logic [17:0] lvp9;
	logic [23:0] wbeat9, wbar9;
	bslpr_pkg::pix_t [bslpr_pkg::NUM_PIX-1:0] pix9;

	always_comb begin
		sel9   = (mode == bslpr_pkg::MODE_PULSE) ? lvp_s8 : hb_s8;
		lvp9   = 18'(sel9) * 18'(lvbr);
		lvb9   = lvp9[16:8];
		wbeat9 = bslpr_pkg::wheel(huebeat_s8);
		wbar9  = bslpr_pkg::wheel(huebar_s8);
		for (int p = 0; p < bslpr_pkg::NUM_PIX; p++) begin
			pix9[p].colour = 24'd0;
			pix9[p].level  = 9'd0;
			unique case (mode)
				bslpr_pkg::MODE_PULSE: begin
					pix9[p].colour = wbeat9;
					pix9[p].level  = lvb9;
				end
				bslpr_pkg::MODE_CHASE: begin
					// chase head is the first comet position
					if (bslpr_pkg::path_pixel(at_s8[0]) == 4'(p)) begin
						pix9[p].colour = wbar9;
						pix9[p].level  = lvbr;
					end
				end
				bslpr_pkg::MODE_COMET: begin
					for (int i = 0; i < 4; i++) begin
						if (bslpr_pkg::path_pixel(at_s8[i]) == 4'(p)) begin
							pix9[p].colour = wbar9;
							pix9[p].level  = cml_s8[i];
						end
					end
				end
				bslpr_pkg::MODE_SWEEP: begin
					pix9[p].colour = wbeat9;
					pix9[p].level  = swl_s8[bslpr_pkg::pixel_column(4'(p))];
				end
				bslpr_pkg::MODE_RAINBOW: begin
					pix9[p].colour = bslpr_pkg::wheel(huebar_s8 + bslpr_pkg::RAINBOW_OFS[p]);
					pix9[p].level  = lvbr;
				end
				bslpr_pkg::MODE_SPARKLE: begin
					for (int k = 0; k < 3; k++) begin
						if (sidx_s8[k] == 4'(p)) begin
							pix9[p].colour = bslpr_pkg::wheel(shue_s8[k]);
							pix9[p].level  = lvbr;
						end
					end
				end
				bslpr_pkg::MODE_HEART: begin
					pix9[p].colour = bslpr_pkg::BLOOD_COLOUR;
					pix9[p].level  = lvb9;
				end
				bslpr_pkg::MODE_SCANNER: begin
					pix9[p].colour = bslpr_pkg::SCAN_COLOUR;
					if (bslpr_pkg::pixel_column(4'(p)) == eye_s8) begin
						pix9[p].level = lvbr;
					end else if (behind_ok_s8 &&
							bslpr_pkg::pixel_column(4'(p)) == behind_s8) begin
						pix9[p].level = trail_s8;
					end
				end
				default: begin
					pix9[p].colour = 24'd0;
					pix9[p].level  = 9'd0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else begin
			if (rdy_7) v_s7 <= in_valid;
			if (rdy_8) v_s8 <= v_s7;
			if (rdy_9) v_s9 <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_7) begin
			sq_s7        <= 17'(rem7) * 17'(rem7);
			a1_s7        <= dm_a1.q[7:0];
			a2_s7        <= dm_a2.q[7:0];
			zone_s7      <= zone7;
			hv_s7        <= hv7;
			head_s7      <= head_p7[11:8];
			huebar_s7    <= hue_p7[15:8];
			huebeat_s7   <= {phase.beat, 6'd0};
			d_s7         <= d7;
			eye_s7       <= eye_t7[9:8];
			behind_s7    <= behind7;
			behind_ok_s7 <= behind_ok7;
		end
		if (rdy_8) begin
			lvp_s8       <= sq_s7[16:8];
			hb_s8        <= hb8;
			trail_s8     <= trp8[16:8];
			sidx_s8      <= sidx8;
			for (int k = 0; k < 3; k++) begin
				shue_s8[k] <= hv_s7[k][23:16];
			end
			swl_s8       <= swl8;
			cml_s8       <= cml8;
			at_s8        <= at8;
			huebar_s8    <= huebar_s7;
			huebeat_s8   <= huebeat_s7;
			eye_s8       <= eye_s7;
			behind_s8    <= behind_s7;
			behind_ok_s8 <= behind_ok_s7;
		end
		if (rdy_9) begin
			pix_s9 <= pix9;
		end
	end

	assign out_valid = v_s9;
	assign pix       = pix_s9;

endmodule

`default_nettype wire

/* hw/rtl/bslpr_scale.sv */
// ----------------------------------------------------------------------------
// bslpr_scale
// Scales each pixel colour by its level and holds the output transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module bslpr_scale (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   in_valid,
	output logic                                        in_ready,
	input  wire bslpr_pkg::pix_t [bslpr_pkg::NUM_PIX-1:0] pix,
	output logic                                        out_valid,
	input  wire logic                                   out_ready,
	output logic [bslpr_pkg::OUT_W-1:0]                 out_data
);

	logic                          v_s10;
	logic                          rdy_10;
	logic [bslpr_pkg::OUT_W-1:0]   data_s10;
	logic [bslpr_pkg::OUT_W-1:0]   data10;
	logic [16:0]                   prod10;

	assign rdy_10   = !v_s10 || out_ready;
	assign in_ready = rdy_10;

	always_comb begin
		data10 = '0;
		for (int p = 0; p < bslpr_pkg::NUM_PIX; p++) begin
			for (int ch = 0; ch < 3; ch++) begin
				prod10 = 17'(pix[p].colour[ch*8 +: 8]) * 17'(pix[p].level);
				data10[p*bslpr_pkg::PIX_W + ch*8 +: 8] = prod10[15:8];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s10 <= 1'b0;
		end else if (rdy_10) begin
			v_s10 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_10) begin
			data_s10 <= data10;
		end
	end

	assign out_valid = v_s10;
	assign out_data  = data_s10;

endmodule

`default_nettype wire

/* hw/rtl/bslpr_checker.sv */
// ----------------------------------------------------------------------------
// bslpr_checker
// Port-level checks of the LED pattern renderer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bslpr_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          s_axis_tvalid,
	input wire logic                          s_axis_tready,
	input wire logic [63:0]                   s_axis_tdata,
	input wire logic                          m_axis_tvalid,
	input wire logic                          m_axis_tready,
	input wire logic [bslpr_pkg::OUT_W-1:0]   m_axis_tdata,
	input wire logic                          cfg_valid,
	input wire logic                          cfg_ready,
	input wire logic                          cfg_index,
	input wire logic [7:0]                    cfg_data
);

	localparam logic [bslpr_pkg::OUT_W-1:0] GB_MASK = {bslpr_pkg::NUM_PIX{24'h00FFFF}};

	logic [3:0] mode_q;
	logic       in_seen;

	assign in_seen = s_axis_tvalid && s_axis_tready && (s_axis_tdata[0] || !s_axis_tdata[0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= bslpr_pkg::MODE_OFF;
		end else if (cfg_valid && cfg_ready && cfg_index == bslpr_pkg::REG_MODE) begin
			mode_q <= cfg_data[3:0];
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("output transaction dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("output data changed while stalled");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with empty output");

	a_off_dark: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (mode_q == bslpr_pkg::MODE_OFF || mode_q > bslpr_pkg::MODE_SCANNER)
		|-> m_axis_tdata == '0)
		else $error("pixels lit in off mode");

	a_scan_red: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && mode_q == bslpr_pkg::MODE_SCANNER && !in_seen
		|-> (m_axis_tdata & GB_MASK) == '0)
		else $error("scanner shows green or blue");

endmodule

bind beat_synced_led_pattern_renderer bslpr_checker u_bslpr_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.cfg_valid     (cfg_valid),
	.cfg_ready     (cfg_ready),
	.cfg_index     (cfg_index),
	.cfg_data      (cfg_data)
);

`default_nettype wire
